@@ hdl/cdconv_pkg.sv @@
// Shared widths, constants and calendar tables for the civil date converter.
package cdconv_pkg;

  localparam int YEAR_W  = 17;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DC_W    = 25;
  localparam int MLEN_W  = 5;

  // register stages of each conversion path
  localparam int C2D_LAT      = 8;
  localparam int D2C_CORE_LAT = 4;

  localparam logic REQ_TO_COUNT = 1'b0;
  localparam logic REQ_TO_DATE  = 1'b1;

  localparam logic [MONTH_W-1:0] MON_NONE = 4'd0;
  localparam logic [MONTH_W-1:0] MON_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR  = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR  = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY  = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN  = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL  = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG  = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP  = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT  = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV  = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC  = 4'd12;

  localparam logic signed [DC_W-1:0] DC_MAX = 25'sh0FFFFFF;
  localparam logic signed [DC_W-1:0] DC_MIN = 25'sh1000000;

  localparam logic signed [26:0] EPOCH_DAYS    = 27'sd719468;
  // epoch offset plus 110 eras, so the shifted count is never negative
  localparam logic signed [26:0] ERA_BIAS_DAYS = 27'sd16790138;
  localparam logic [18:0]        ERA_BIAS_YEARS = 19'd44000;
  localparam logic [25:0]        DAYS_PER_ERA  = 26'd146097;

  // reciprocal multipliers: floor(x/d) = (x*K) >> S over the ranges used
  localparam logic [26:0] K_ERA  = 27'd120414424;  // /146097, S = 44
  localparam logic [17:0] K_1460 = 18'd183860;     // /1460 at S = 28, /365 at S = 26
  localparam logic [16:0] K_25   = 17'd83887;      // /25, S = 21
  localparam logic signed [16:0] Q4_BIAS  = 17'sd16400;
  localparam logic signed [11:0] Q25_BIAS = 12'sd656;

  // divisibility by 25: modular inverse mod 2^18 and its limit
  localparam logic signed [17:0] YEAR_BIAS = 18'sd65550;
  localparam logic [17:0]        INV25     = 18'd220201;
  localparam logic [17:0]        DIV25_MAX = 18'd10485;

  // day of the March-based year on which month index mp starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [MLEN_W-1:0] n;
    case (m)
      MON_FEB: n = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: n = 5'd31;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/cdconv_d2c.sv @@
// Date to day count pipeline, padded to the latency of the reverse path.
module cdconv_d2c (
  input  logic                                    clk,
  input  logic signed [cdconv_pkg::YEAR_W-1:0]    year_in,
  input  logic        [cdconv_pkg::MONTH_W-1:0]   month_in,
  input  logic        [cdconv_pkg::DAY_W-1:0]     day_in,
  output logic signed [cdconv_pkg::DC_W-1:0]      day_count,
  output logic                                    range_error,
  output logic signed [cdconv_pkg::YEAR_W-1:0]    year,
  output logic        [cdconv_pkg::MONTH_W-1:0]   month,
  output logic        [cdconv_pkg::DAY_W-1:0]     day
);

  localparam int PAD = cdconv_pkg::C2D_LAT - cdconv_pkg::D2C_CORE_LAT;

  typedef struct packed {
    logic                                  ok;
    logic signed [cdconv_pkg::YEAR_W-1:0]  year;
    logic        [cdconv_pkg::MONTH_W-1:0] month;
    logic        [cdconv_pkg::DAY_W-1:0]   day;
  } echo_t;

  typedef struct packed {
    logic signed [cdconv_pkg::DC_W-1:0] count;
    logic                               err;
  } res_t;

  echo_t echo_r [cdconv_pkg::C2D_LAT];
  res_t  res_r  [PAD+1];

  logic               mle2;
  logic               month_ok;
  logic signed [17:0] yp;
  logic        [3:0]  mp;
  logic signed [10:0] doy;
  logic signed [26:0] yp365;
  logic signed [26:0] base_nxt;
  logic signed [15:0] q4;
  logic        [15:0] u_nxt;
  logic signed [26:0] base_r;
  logic signed [15:0] q4_r;
  logic        [15:0] u_r;

  logic        [32:0] prod25;
  logic        [10:0] q25u_r;
  logic signed [26:0] part_r;

  logic signed [11:0] q25;
  logic signed [11:0] q100;
  logic signed [26:0] cnt_nxt;
  logic signed [26:0] cnt_r;
  res_t               res_nxt;
  echo_t              echo_nxt;

  always_comb begin
    mle2     = (month_in <= cdconv_pkg::MON_FEB);
    month_ok = (month_in >= cdconv_pkg::MON_JAN) && (month_in <= cdconv_pkg::MON_DEC);
    yp       = $signed({year_in[cdconv_pkg::YEAR_W-1], year_in}) - $signed({17'd0, mle2});
    mp       = mle2 ? (month_in + 4'd9) : (month_in - 4'd3);
    doy      = $signed({2'b00, cdconv_pkg::month_start(mp)}) + $signed({6'd0, day_in})
               - 11'sd1;
    yp365    = $signed({{9{yp[17]}}, yp}) * 27'sd365;
    base_nxt = yp365 + 27'(doy) - cdconv_pkg::EPOCH_DAYS;
    q4       = yp[17:2];
    u_nxt    = 16'($signed({q4[15], q4}) + cdconv_pkg::Q4_BIAS);
    echo_nxt.ok    = month_ok;
    echo_nxt.year  = year_in;
    echo_nxt.month = month_ok ? month_in : cdconv_pkg::MON_NONE;
    echo_nxt.day   = month_ok ? day_in : 5'd0;
  end

  assign prod25 = {17'd0, u_r} * {16'd0, cdconv_pkg::K_25};

  always_comb begin
    q25     = $signed({1'b0, q25u_r}) - cdconv_pkg::Q25_BIAS;
    q100    = q25 >>> 2;
    cnt_nxt = part_r - 27'(q25) + 27'(q100);
  end

  always_comb begin
    res_nxt.err   = 1'b0;
    res_nxt.count = cnt_r[cdconv_pkg::DC_W-1:0];
    if (!echo_r[2].ok) begin
      res_nxt.err   = 1'b1;
      res_nxt.count = '0;
    end else if (cnt_r > 27'(cdconv_pkg::DC_MAX)) begin
      res_nxt.err   = 1'b1;
      res_nxt.count = cdconv_pkg::DC_MAX;
    end else if (cnt_r < 27'(cdconv_pkg::DC_MIN)) begin
      res_nxt.err   = 1'b1;
      res_nxt.count = cdconv_pkg::DC_MIN;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    q4_r      <= q4;
    u_r       <= u_nxt;
    q25u_r    <= prod25[31:21];
    part_r    <= base_r + 27'(q4_r);
    cnt_r     <= cnt_nxt;
    res_r[0]  <= res_nxt;
    echo_r[0] <= echo_nxt;
    for (int i = 1; i < cdconv_pkg::C2D_LAT; i++) begin
      echo_r[i] <= echo_r[i-1];
    end
    for (int i = 1; i <= PAD; i++) begin
      res_r[i] <= res_r[i-1];
    end
  end

  assign day_count   = res_r[PAD].count;
  assign range_error = res_r[PAD].err;
  assign year        = echo_r[cdconv_pkg::C2D_LAT-1].year;
  assign month       = echo_r[cdconv_pkg::C2D_LAT-1].month;
  assign day         = echo_r[cdconv_pkg::C2D_LAT-1].day;

endmodule

@@ hdl/cdconv_c2d.sv @@
// Day count to date pipeline, eight register stages.
module cdconv_c2d (
  input  logic                                    clk,
  input  logic signed [cdconv_pkg::DC_W-1:0]      day_count_in,
  output logic signed [cdconv_pkg::DC_W-1:0]      day_count,
  output logic signed [cdconv_pkg::YEAR_W-1:0]    year,
  output logic        [cdconv_pkg::MONTH_W-1:0]   month,
  output logic        [cdconv_pkg::DAY_W-1:0]     day
);

  logic signed [cdconv_pkg::DC_W-1:0] dc_r [cdconv_pkg::C2D_LAT];

  logic [25:0] v_nxt;
  logic [25:0] v_r;
  logic [52:0] pera;
  logic [7:0]  era2_r;
  logic [25:0] v2_r;
  logic [25:0] em;
  logic [17:0] doe3_r;
  logic [7:0]  era3_r;
  logic [35:0] p1460;
  logic [2:0]  c36;
  logic [17:0] doe4_r;
  logic [6:0]  q1460_r;
  logic [2:0]  c36_r;
  logic        f_r;
  logic [7:0]  era4_r;
  logic [17:0] n_r;
  logic [17:0] doe5_r;
  logic [7:0]  era5_r;
  logic [35:0] pyoe;
  logic [8:0]  yoe6_r;
  logic [17:0] doe6_r;
  logic [7:0]  era6_r;
  logic [1:0]  c100;
  logic [17:0] ysub;
  logic [8:0]  doy7_r;
  logic [8:0]  yoe7_r;
  logic [7:0]  era7_r;
  logic [3:0]  mp;
  logic [8:0]  dsub;
  logic [3:0]  month_nxt;
  logic [18:0] year_nxt;
  logic signed [cdconv_pkg::YEAR_W-1:0] year8_r;
  logic [cdconv_pkg::MONTH_W-1:0]       month8_r;
  logic [cdconv_pkg::DAY_W-1:0]         day8_r;

  assign v_nxt = 26'($signed({{2{day_count_in[cdconv_pkg::DC_W-1]}}, day_count_in})
                     + cdconv_pkg::ERA_BIAS_DAYS);
  assign pera  = 53'(v_r) * 53'(cdconv_pkg::K_ERA);
  assign em    = 26'(era2_r) * cdconv_pkg::DAYS_PER_ERA;
  assign p1460 = 36'(doe3_r) * 36'(cdconv_pkg::K_1460);

  always_comb begin
    c36 = 3'(doe3_r >= 18'd36524) + 3'(doe3_r >= 18'd73048)
        + 3'(doe3_r >= 18'd109572) + 3'(doe3_r >= 18'd146096);
  end

  assign pyoe = 36'(n_r) * 36'(cdconv_pkg::K_1460);

  always_comb begin
    c100 = 2'(yoe6_r >= 9'd100) + 2'(yoe6_r >= 9'd200) + 2'(yoe6_r >= 9'd300);
    ysub = 18'(yoe6_r) * 18'd365 + 18'(yoe6_r[8:2]) - 18'(c100);
  end

  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mp = mp + 4'(doy7_r >= cdconv_pkg::month_start(4'(k)));
    end
    dsub      = doy7_r - cdconv_pkg::month_start(mp) + 9'd1;
    month_nxt = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
    year_nxt  = 19'(yoe7_r) + 19'(era7_r) * 19'd400 + 19'(mp >= 4'd10)
              - cdconv_pkg::ERA_BIAS_YEARS;
  end

  always_ff @(posedge clk) begin
    dc_r[0]  <= day_count_in;
    for (int i = 1; i < cdconv_pkg::C2D_LAT; i++) begin
      dc_r[i] <= dc_r[i-1];
    end
    v_r      <= v_nxt;
    era2_r   <= pera[51:44];
    v2_r     <= v_r;
    doe3_r   <= 18'(v2_r - em);
    era3_r   <= era2_r;
    doe4_r   <= doe3_r;
    q1460_r  <= p1460[34:28];
    c36_r    <= c36;
    f_r      <= (doe3_r == 18'd146096);
    era4_r   <= era3_r;
    n_r      <= doe4_r - 18'(q1460_r) + 18'(c36_r) - 18'(f_r);
    doe5_r   <= doe4_r;
    era5_r   <= era4_r;
    yoe6_r   <= pyoe[34:26];
    doe6_r   <= doe5_r;
    era6_r   <= era5_r;
    doy7_r   <= 9'(doe6_r - ysub);
    yoe7_r   <= yoe6_r;
    era7_r   <= era6_r;
    year8_r  <= year_nxt[cdconv_pkg::YEAR_W-1:0];
    month8_r <= month_nxt;
    day8_r   <= dsub[cdconv_pkg::DAY_W-1:0];
  end

  assign day_count = dc_r[cdconv_pkg::C2D_LAT-1];
  assign year      = year8_r;
  assign month     = month8_r;
  assign day       = day8_r;

endmodule

@@ hdl/civil_date_day_count_converter.sv @@
// Civil date / day count converter top level: control pipeline, merge and leap stage.
// Throughput: one item per cycle; busy stays low after reset, results leave in order.
// Depth is set by the day-count-to-date path: eight stages around its four multipliers,
// then one merge stage and one leap-year/month-length stage.
// Reset (synchronous, active low) clears all valid bits; busy is high during reset
// and for the first cycle after it.
module civil_date_day_count_converter (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_req_type,
  input  logic signed [cdconv_pkg::YEAR_W-1:0]    in_year_in,
  input  logic        [cdconv_pkg::MONTH_W-1:0]   in_month_in,
  input  logic        [cdconv_pkg::DAY_W-1:0]     in_day_in,
  input  logic signed [cdconv_pkg::DC_W-1:0]      in_day_count_in,
  output logic                                    out_valid,
  output logic signed [cdconv_pkg::DC_W-1:0]      out_day_count_out,
  output logic signed [cdconv_pkg::YEAR_W-1:0]    out_year_out,
  output logic        [cdconv_pkg::MONTH_W-1:0]   out_month_out,
  output logic        [cdconv_pkg::DAY_W-1:0]     out_day_out,
  output logic                                    out_leap_year,
  output logic        [cdconv_pkg::MLEN_W-1:0]    out_month_length,
  output logic                                    out_range_error
);

  typedef struct packed {
    logic vld;
    logic req;
  } ctl_t;

  ctl_t ctl_r [cdconv_pkg::C2D_LAT];
  logic busy_r;

  logic signed [cdconv_pkg::DC_W-1:0]    d2c_count;
  logic                                  d2c_err;
  logic signed [cdconv_pkg::YEAR_W-1:0]  d2c_year;
  logic        [cdconv_pkg::MONTH_W-1:0] d2c_month;
  logic        [cdconv_pkg::DAY_W-1:0]   d2c_day;
  logic signed [cdconv_pkg::DC_W-1:0]    c2d_count;
  logic signed [cdconv_pkg::YEAR_W-1:0]  c2d_year;
  logic        [cdconv_pkg::MONTH_W-1:0] c2d_month;
  logic        [cdconv_pkg::DAY_W-1:0]   c2d_day;

  logic signed [cdconv_pkg::DC_W-1:0]    sel_count;
  logic                                  sel_err;
  logic signed [cdconv_pkg::YEAR_W-1:0]  sel_year;
  logic        [cdconv_pkg::MONTH_W-1:0] sel_month;
  logic        [cdconv_pkg::DAY_W-1:0]   sel_day;
  logic        [17:0]                    ybias;
  logic        [17:0]                    modp;

  logic                                  m_vld_r;
  logic signed [cdconv_pkg::DC_W-1:0]    m_count_r;
  logic                                  m_err_r;
  logic signed [cdconv_pkg::YEAR_W-1:0]  m_year_r;
  logic        [cdconv_pkg::MONTH_W-1:0] m_month_r;
  logic        [cdconv_pkg::DAY_W-1:0]   m_day_r;
  logic        [17:0]                    m_mod_r;
  logic                                  leap;

  logic                                  out_valid_r;
  logic signed [cdconv_pkg::DC_W-1:0]    out_count_r;
  logic signed [cdconv_pkg::YEAR_W-1:0]  out_year_r;
  logic        [cdconv_pkg::MONTH_W-1:0] out_month_r;
  logic        [cdconv_pkg::DAY_W-1:0]   out_day_r;
  logic                                  out_leap_r;
  logic        [cdconv_pkg::MLEN_W-1:0]  out_mlen_r;
  logic                                  out_err_r;

  cdconv_d2c u_d2c (
    .clk         (clk),
    .year_in     (in_year_in),
    .month_in    (in_month_in),
    .day_in      (in_day_in),
    .day_count   (d2c_count),
    .range_error (d2c_err),
    .year        (d2c_year),
    .month       (d2c_month),
    .day         (d2c_day)
  );

  cdconv_c2d u_c2d (
    .clk          (clk),
    .day_count_in (in_day_count_in),
    .day_count    (c2d_count),
    .year         (c2d_year),
    .month        (c2d_month),
    .day          (c2d_day)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      for (int i = 0; i < cdconv_pkg::C2D_LAT; i++) begin
        ctl_r[i] <= '0;
      end
      m_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      ctl_r[0].vld <= start && !busy_r;
      ctl_r[0].req <= in_req_type;
      for (int i = 1; i < cdconv_pkg::C2D_LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      m_vld_r     <= ctl_r[cdconv_pkg::C2D_LAT-1].vld;
      out_valid_r <= m_vld_r;
    end
  end

  always_comb begin
    if (ctl_r[cdconv_pkg::C2D_LAT-1].req == cdconv_pkg::REQ_TO_DATE) begin
      sel_count = c2d_count;
      sel_err   = 1'b0;
      sel_year  = c2d_year;
      sel_month = c2d_month;
      sel_day   = c2d_day;
    end else begin
      sel_count = d2c_count;
      sel_err   = d2c_err;
      sel_year  = d2c_year;
      sel_month = d2c_month;
      sel_day   = d2c_day;
    end
    ybias = 18'($signed({sel_year[cdconv_pkg::YEAR_W-1], sel_year}) + cdconv_pkg::YEAR_BIAS);
    modp  = ybias * cdconv_pkg::INV25;
  end

  always_comb begin
    leap = (m_year_r[1:0] == 2'b00)
        && ((m_mod_r > cdconv_pkg::DIV25_MAX) || (m_year_r[3:0] == 4'b0000));
  end

  always_ff @(posedge clk) begin
    m_count_r   <= sel_count;
    m_err_r     <= sel_err;
    m_year_r    <= sel_year;
    m_month_r   <= sel_month;
    m_day_r     <= sel_day;
    m_mod_r     <= modp;
    out_count_r <= m_count_r;
    out_err_r   <= m_err_r;
    out_year_r  <= m_year_r;
    out_month_r <= m_month_r;
    out_day_r   <= m_day_r;
    out_leap_r  <= leap;
    out_mlen_r  <= cdconv_pkg::month_days(m_month_r, leap);
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_day_count_out = out_count_r;
  assign out_year_out      = out_year_r;
  assign out_month_out     = out_month_r;
  assign out_day_out       = out_day_r;
  assign out_leap_year     = out_leap_r;
  assign out_month_length  = out_mlen_r;
  assign out_range_error   = out_err_r;

endmodule

@@ hdl/cdconv_checker.sv @@
// Port-level checker for the civil date converter, bound to the top level.
module cdconv_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    start,
  input logic                                    busy,
  input logic                                    out_valid,
  input logic signed [cdconv_pkg::DC_W-1:0]      out_day_count_out,
  input logic        [cdconv_pkg::MONTH_W-1:0]   out_month_out,
  input logic                                    out_leap_year,
  input logic        [cdconv_pkg::MLEN_W-1:0]    out_month_length,
  input logic                                    out_range_error
);

  localparam int LAT = cdconv_pkg::C2D_LAT + 2;

  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_month_out == cdconv_pkg::MON_FEB
      |-> out_month_length == (out_leap_year ? 5'd29 : 5'd28))
    else $error("february length does not follow leap flag");

  a_bad_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_month_out == cdconv_pkg::MON_NONE
      |-> out_range_error && out_day_count_out == '0 && out_month_length == '0)
    else $error("invalid month result not cleared");

endmodule

bind civil_date_day_count_converter cdconv_checker u_cdconv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_day_count_out (out_day_count_out),
  .out_month_out     (out_month_out),
  .out_leap_year     (out_leap_year),
  .out_month_length  (out_month_length),
  .out_range_error   (out_range_error)
);

@@ tb/tb_civil_date_day_count_converter.sv @@
// Self-checking testbench for the civil date / day count converter in both directions.
`timescale 1ns / 100ps

module tb_civil_date_day_count_converter;
  import cdconv_pkg::*;

  localparam int WATCHDOG_LIMIT = 200;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic signed [DC_W-1:0]   day_count;
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic                     leap;
    logic [MLEN_W-1:0]        mlen;
    logic                     range_err;
  } conv_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_req_type = REQ_TO_COUNT;
  logic signed [YEAR_W-1:0]  in_year_in = '0;
  logic [MONTH_W-1:0]        in_month_in = MON_NONE;
  logic [DAY_W-1:0]          in_day_in = '0;
  logic signed [DC_W-1:0]    in_day_count_in = '0;
  logic                      out_valid;
  logic signed [DC_W-1:0]    out_day_count_out;
  logic signed [YEAR_W-1:0]  out_year_out;
  logic [MONTH_W-1:0]        out_month_out;
  logic [DAY_W-1:0]          out_day_out;
  logic                      out_leap_year;
  logic [MLEN_W-1:0]         out_month_length;
  logic                      out_range_error;

  conv_result_t expected_results[$];
  int fail_count = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  civil_date_day_count_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_year_in        (in_year_in),
    .in_month_in       (in_month_in),
    .in_day_in         (in_day_in),
    .in_day_count_in   (in_day_count_in),
    .out_valid         (out_valid),
    .out_day_count_out (out_day_count_out),
    .out_year_out      (out_year_out),
    .out_month_out     (out_month_out),
    .out_day_out       (out_day_out),
    .out_leap_year     (out_leap_year),
    .out_month_length  (out_month_length),
    .out_range_error   (out_range_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic logic is_leap_year(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [MLEN_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic lp);
    case (m)
      MON_FEB: return lp ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic longint days_since_epoch(input longint y, input longint m,
                                              input longint d);
    longint era, yoe, mp, doy, doe;
    if (m <= 2) y -= 1;
    era = floor_quot(y, 400);
    yoe = y - era * 400;
    mp = (m > 2) ? (m - 3) : (m + 9);
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic void civil_from_count(input longint t, output longint y,
                                           output longint m, output longint d);
    longint era, doe, yoe, doy, mp;
    t += 719468;
    era = floor_quot(t, 146097);
    doe = t - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = (mp < 10) ? (mp + 3) : (mp - 9);
    y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  function automatic conv_result_t convert_item(input logic req,
                                                input logic signed [YEAR_W-1:0] y_in,
                                                input logic [MONTH_W-1:0] m_in,
                                                input logic [DAY_W-1:0] d_in,
                                                input logic signed [DC_W-1:0] c_in);
    conv_result_t r;
    longint cnt, yr, mo, dy;
    cnt = 0;
    r.range_err = 1'b0;
    r.mlen = '0;
    if (req == REQ_TO_COUNT) begin
      yr = y_in;
      mo = m_in;
      dy = d_in;
      r.leap = is_leap_year(yr);
      if (m_in < MON_JAN || m_in > MON_DEC) begin
        r.range_err = 1'b1;
        mo = 0;
        dy = 0;
      end else begin
        cnt = days_since_epoch(yr, mo, dy);
        if (cnt > longint'(DC_MAX)) begin
          cnt = DC_MAX;
          r.range_err = 1'b1;
        end else if (cnt < longint'(DC_MIN)) begin
          cnt = DC_MIN;
          r.range_err = 1'b1;
        end
        r.mlen = days_in_month(m_in, r.leap);
      end
    end else begin
      cnt = c_in;
      civil_from_count(cnt, yr, mo, dy);
      r.leap = is_leap_year(yr);
      r.mlen = days_in_month(mo[MONTH_W-1:0], r.leap);
    end
    r.day_count = cnt[DC_W-1:0];
    r.year = yr[YEAR_W-1:0];
    r.month = mo[MONTH_W-1:0];
    r.day = dy[DAY_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_item(input logic req, input logic signed [YEAR_W-1:0] yr,
                           input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
                           input logic signed [DC_W-1:0] cnt);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_year_in <= yr;
    in_month_in <= mo;
    in_day_in <= dy;
    in_day_count_in <= cnt;
    do @(posedge clk); while (busy);
    expected_results.push_back(convert_item(req, yr, mo, dy, cnt));
  endtask

  task automatic test_date_extremes();
    send_item(REQ_TO_COUNT, 1970, MON_JAN, 1, 0);
    send_item(REQ_TO_COUNT, 2000, MON_FEB, 29, 0);
    send_item(REQ_TO_COUNT, 1900, MON_FEB, 28, 0);
    send_item(REQ_TO_COUNT, 2001, MON_FEB, 31, 0);
    send_item(REQ_TO_COUNT, 2024, MON_MAR, 0, 0);
    send_item(REQ_TO_COUNT, 2023, MON_APR, 31, 0);
    send_item(REQ_TO_COUNT, 2023, MON_DEC, 31, 0);
    send_item(REQ_TO_COUNT, -1, MON_MAR, 1, 0);
    send_item(REQ_TO_COUNT, 65535, MON_DEC, 31, 0);
    send_item(REQ_TO_COUNT, -65536, MON_JAN, 0, 0);
  endtask

  task automatic test_invalid_month();
    send_item(REQ_TO_COUNT, 2000, MON_NONE, 15, 0);
    send_item(REQ_TO_COUNT, 1999, 4'd13, 31, 0);
    send_item(REQ_TO_COUNT, -65536, 4'd14, 1, 0);
    send_item(REQ_TO_COUNT, 65535, 4'd15, 0, 0);
  endtask

  task automatic test_count_extremes();
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, 0);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, -1);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, DC_MAX);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, DC_MIN);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, 59);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, 10957);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, 11016);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, -719468);
    send_item(REQ_TO_DATE, 0, MON_NONE, 0, -719469);
  endtask

  task automatic test_random_mix(input int n, input int pct);
    logic signed [YEAR_W-1:0] yr;
    logic [MONTH_W-1:0] mo;
    logic signed [DC_W-1:0] cnt;
    idle_pct = pct;
    repeat (n) begin
      case ($urandom_range(3))
        0: yr = YEAR_W'($urandom());
        1: yr = YEAR_W'($urandom_range(1600, 2400));
        2: yr = YEAR_W'($urandom_range(47850, 47950));
        default: yr = YEAR_W'(-int'($urandom_range(43865, 44065)));
      endcase
      if ($urandom_range(4) == 0) mo = MONTH_W'($urandom());
      else mo = MONTH_W'($urandom_range(MON_JAN, MON_DEC));
      case ($urandom_range(3))
        0, 1: cnt = DC_W'($urandom());
        2: cnt = DC_W'(int'($urandom_range(0, 400000)) - 200000);
        default: cnt = $urandom_range(1) ? DC_MAX - DC_W'($urandom_range(2000))
                                         : DC_MIN + DC_W'($urandom_range(2000));
      endcase
      send_item(1'($urandom_range(1)), yr, mo, DAY_W'($urandom()), cnt);
    end
  endtask

  always @(posedge clk) begin
    conv_result_t want;
    if (out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no pending item");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("day_count_out", want.day_count, out_day_count_out);
        check_field("year_out", want.year, out_year_out);
        check_field("month_out", want.month, out_month_out);
        check_field("day_out", want.day, out_day_out);
        check_field("leap_year", want.leap, out_leap_year);
        check_field("month_length", want.mlen, out_month_length);
        check_field("range_error", want.range_err, out_range_error);
      end
    end
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 35;
    test_date_extremes();
    test_invalid_month();
    test_count_extremes();
    test_random_mix(340, 35);
    test_random_mix(330, 83);
    test_random_mix(330, 0);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
